// ===== hw/rtl/wsfd_pkg.sv =====
package wsfd_pkg;

    typedef enum logic [3:0] {
        PH_HDR0    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_EXT0    = 4'd2,
        PH_EXT1    = 4'd3,
        PH_KEY     = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_CLOSED  = 4'd6,
        PH_STUCK   = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_CLOSE    = 2'd1,
        KIND_FRAGMENT = 2'd2,
        KIND_OVERSIZE = 2'd3
    } kind_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] payload;
        logic       last;
    } result_t;

    localparam int          CLOSE_BIT    = 3;
    localparam int          FIN_BIT      = 7;
    localparam int          MASK_BIT     = 7;
    localparam logic [6:0]  LEN_EXT16    = 7'd126;
    localparam logic [6:0]  LEN_OVERSIZE = 7'd127;
    localparam logic [15:0] EXT_OVERSIZE = 16'd127;
    localparam logic [1:0]  KEY_LAST     = 2'd3;

endpackage

// ===== hw/rtl/wsfd_parser.sv =====
module wsfd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    output wsfd_pkg::result_t  res
);

    wsfd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       first_header_reg, first_header_next;
    logic             masked_reg, masked_next;
    logic [31:0]      mask_key_reg, mask_key_next;
    logic [1:0]       key_index_reg, key_index_next;
    logic [15:0]      remaining_reg, remaining_next;
    logic [7:0]       ext_high_reg, ext_high_next;

    logic [6:0]       len7;
    logic [15:0]      len16;
    logic [15:0]      rem_dec;
    logic [7:0]       key_byte;

    assign len7    = rx_byte[6:0];
    assign len16   = {ext_high_reg, rx_byte};
    assign rem_dec = remaining_reg - 16'd1;

    always_comb
    begin
        case (key_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        first_header_next = first_header_reg;
        masked_next       = masked_reg;
        mask_key_next     = mask_key_reg;
        key_index_next    = key_index_reg;
        remaining_next    = remaining_reg;
        ext_high_next     = ext_high_reg;
        if (accept)
        begin
            case (phase_reg)
                wsfd_pkg::PH_HDR0:
                begin
                    first_header_next = rx_byte;
                    phase_next        = wsfd_pkg::PH_HDR1;
                end
                wsfd_pkg::PH_HDR1:
                begin
                    if (first_header_reg[wsfd_pkg::CLOSE_BIT])
                    begin
                        phase_next = wsfd_pkg::PH_CLOSED;
                    end
                    else if (!first_header_reg[wsfd_pkg::FIN_BIT])
                    begin
                        phase_next = wsfd_pkg::PH_STUCK;
                    end
                    else
                    begin
                        masked_next = rx_byte[wsfd_pkg::MASK_BIT];
                        if (len7 == wsfd_pkg::LEN_OVERSIZE)
                        begin
                            phase_next = wsfd_pkg::PH_STUCK;
                        end
                        else if (len7 == wsfd_pkg::LEN_EXT16)
                        begin
                            phase_next = wsfd_pkg::PH_EXT0;
                        end
                        else
                        begin
                            remaining_next = {9'd0, len7};
                            key_index_next = 2'd0;
                            if (rx_byte[wsfd_pkg::MASK_BIT])
                                phase_next = wsfd_pkg::PH_KEY;
                            else if (len7 == 7'd0)
                                phase_next = wsfd_pkg::PH_HDR0;
                            else
                                phase_next = wsfd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                wsfd_pkg::PH_EXT0:
                begin
                    ext_high_next = rx_byte;
                    phase_next    = wsfd_pkg::PH_EXT1;
                end
                wsfd_pkg::PH_EXT1:
                begin
                    if (len16 == wsfd_pkg::EXT_OVERSIZE)
                    begin
                        phase_next = wsfd_pkg::PH_STUCK;
                    end
                    else
                    begin
                        remaining_next = len16;
                        key_index_next = 2'd0;
                        if (masked_reg)
                            phase_next = wsfd_pkg::PH_KEY;
                        else if (len16 == 16'd0)
                            phase_next = wsfd_pkg::PH_HDR0;
                        else
                            phase_next = wsfd_pkg::PH_PAYLOAD;
                    end
                end
                wsfd_pkg::PH_KEY:
                begin
                    mask_key_next = {mask_key_reg[23:0], rx_byte};
                    if (key_index_reg == wsfd_pkg::KEY_LAST)
                    begin
                        key_index_next = 2'd0;
                        if (remaining_reg == 16'd0)
                            phase_next = wsfd_pkg::PH_HDR0;
                        else
                            phase_next = wsfd_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        key_index_next = key_index_reg + 2'd1;
                    end
                end
                wsfd_pkg::PH_PAYLOAD:
                begin
                    remaining_next = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        key_index_next = 2'd0;
                        phase_next     = wsfd_pkg::PH_HDR0;
                    end
                    else
                    begin
                        key_index_next = key_index_reg + 2'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        res.valid   = 1'b0;
        res.kind    = wsfd_pkg::KIND_DATA;
        res.payload = 8'd0;
        res.last    = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                wsfd_pkg::PH_HDR1:
                begin
                    if (first_header_reg[wsfd_pkg::CLOSE_BIT])
                    begin
                        res.valid = 1'b1;
                        res.kind  = wsfd_pkg::KIND_CLOSE;
                    end
                    else if (!first_header_reg[wsfd_pkg::FIN_BIT])
                    begin
                        res.valid = 1'b1;
                        res.kind  = wsfd_pkg::KIND_FRAGMENT;
                    end
                    else if (len7 == wsfd_pkg::LEN_OVERSIZE)
                    begin
                        res.valid = 1'b1;
                        res.kind  = wsfd_pkg::KIND_OVERSIZE;
                    end
                end
                wsfd_pkg::PH_EXT1:
                begin
                    if (len16 == wsfd_pkg::EXT_OVERSIZE)
                    begin
                        res.valid = 1'b1;
                        res.kind  = wsfd_pkg::KIND_OVERSIZE;
                    end
                end
                wsfd_pkg::PH_PAYLOAD:
                begin
                    res.valid   = 1'b1;
                    res.kind    = wsfd_pkg::KIND_DATA;
                    res.payload = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
                    res.last    = (rem_dec == 16'd0);
                end
                default:
                begin
                    res.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= wsfd_pkg::PH_HDR0;
            first_header_reg <= 8'd0;
            masked_reg       <= 1'b0;
            mask_key_reg     <= 32'd0;
            key_index_reg    <= 2'd0;
            remaining_reg    <= 16'd0;
            ext_high_reg     <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            first_header_reg <= first_header_next;
            masked_reg       <= masked_next;
            mask_key_reg     <= mask_key_next;
            key_index_reg    <= key_index_next;
            remaining_reg    <= remaining_next;
            ext_high_reg     <= ext_high_next;
        end
    end

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind != wsfd_pkg::KIND_DATA) |-> (res.payload == 8'd0 && !res.last))
        else $error("status result carries payload data");

    a_closed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsfd_pkg::PH_CLOSED) |=> (phase_reg == wsfd_pkg::PH_CLOSED))
        else $error("left closed state");

    a_stuck_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsfd_pkg::PH_STUCK) |=> (phase_reg == wsfd_pkg::PH_STUCK))
        else $error("left stuck state");

    a_key_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (key_index_reg != 2'd0)
            |-> (phase_reg == wsfd_pkg::PH_KEY || phase_reg == wsfd_pkg::PH_PAYLOAD))
        else $error("key index nonzero outside key or payload");

    a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsfd_pkg::PH_PAYLOAD) |-> (remaining_reg != 16'd0))
        else $error("payload phase with nothing remaining");

endmodule

// ===== hw/rtl/wsfd_out_reg.sv =====
module wsfd_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  wsfd_pkg::result_t  res,
    output logic               take,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [7:0]         payload,
    output logic               last
);

    logic       valid_reg, valid_next;
    logic [1:0] kind_reg;
    logic [7:0] payload_reg;
    logic       last_reg;

    assign take       = !valid_reg || out_ready;
    assign valid_next = take ? res.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && res.valid)
        begin
            kind_reg    <= res.kind;
            payload_reg <= res.payload;
            last_reg    <= res.last;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign payload   = payload_reg;
    assign last      = last_reg;

endmodule

// ===== hw/rtl/websocket_frame_deframer_core.sv =====
// WebSocket frame deframer core.
// Input channel: one received byte (rx_byte) per request on in_valid/in_ready.
// Output channel: zero or one result per input byte on out_valid/out_ready,
// carrying kind (payload byte, close, fragmented error, oversize error),
// the unmasked payload byte and a last flag on the final byte of a frame.
// Header, length and key bytes yield no result except a close/error status.
// A result is presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the receiver stalls; the header parser
// updates as the byte is taken and the result lands in a single output register.
// When the receiver stalls, the held result stays in the output register and
// in_ready drops until it is taken; a byte is accepted in the same cycle the
// held result drains.
// Reset clears the parser to await the first header byte and empties the
// output register. After a close the block ignores further bytes, and after
// an error it sticks, both until the next reset.
module websocket_frame_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] payload,
    output logic       last
);

    wsfd_pkg::result_t res;
    logic              accept;

    assign accept = in_valid && in_ready;

    wsfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .res     (res)
    );

    wsfd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .take      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .payload   (payload),
        .last      (last)
    );

endmodule

// ===== sim/wsfd_frame_checker.sv =====
module wsfd_frame_checker
    import wsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] kind,
    input  logic [7:0] payload,
    input  logic       last,
    output int         fails,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload;
        logic       last;
    } frame_result_t;

    frame_result_t pending_results[$];

    phase_t      parse_phase;
    logic [7:0]  first_hdr;
    logic        mask_on;
    logic [31:0] mask_key;
    logic [1:0]  key_pos;
    logic [15:0] bytes_left;
    logic [7:0]  len_hi;

    function automatic void queue_result(input kind_t k, input logic [7:0] d, input logic l);
        frame_result_t r;
        r.kind    = k;
        r.payload = d;
        r.last    = l;
        pending_results.push_back(r);
    endfunction

    function automatic void start_body();
        key_pos = 2'd0;
        if (mask_on)
            parse_phase = PH_KEY;
        else if (bytes_left == 16'd0)
            parse_phase = PH_HDR0;
        else
            parse_phase = PH_PAYLOAD;
    endfunction

    function automatic void deframe(input logic [7:0] b);
        logic [15:0] ext_len;
        logic [7:0]  data;
        case (parse_phase)
            PH_HDR0:
            begin
                first_hdr   = b;
                parse_phase = PH_HDR1;
            end
            PH_HDR1:
            begin
                if (first_hdr[CLOSE_BIT])
                begin
                    parse_phase = PH_CLOSED;
                    queue_result(KIND_CLOSE, 8'h00, 1'b0);
                end
                else if (!first_hdr[FIN_BIT])
                begin
                    parse_phase = PH_STUCK;
                    queue_result(KIND_FRAGMENT, 8'h00, 1'b0);
                end
                else
                begin
                    mask_on = b[MASK_BIT];
                    if (b[6:0] == LEN_OVERSIZE)
                    begin
                        parse_phase = PH_STUCK;
                        queue_result(KIND_OVERSIZE, 8'h00, 1'b0);
                    end
                    else if (b[6:0] == LEN_EXT16)
                        parse_phase = PH_EXT0;
                    else
                    begin
                        bytes_left = {9'd0, b[6:0]};
                        start_body();
                    end
                end
            end
            PH_EXT0:
            begin
                len_hi      = b;
                parse_phase = PH_EXT1;
            end
            PH_EXT1:
            begin
                ext_len = {len_hi, b};
                if (ext_len == EXT_OVERSIZE)
                begin
                    parse_phase = PH_STUCK;
                    queue_result(KIND_OVERSIZE, 8'h00, 1'b0);
                end
                else
                begin
                    bytes_left = ext_len;
                    start_body();
                end
            end
            PH_KEY:
            begin
                mask_key = {mask_key[23:0], b};
                if (key_pos == KEY_LAST)
                begin
                    key_pos     = 2'd0;
                    parse_phase = (bytes_left == 16'd0) ? PH_HDR0 : PH_PAYLOAD;
                end
                else
                    key_pos = key_pos + 2'd1;
            end
            PH_PAYLOAD:
            begin
                data = b;
                if (mask_on)
                    data = data ^ mask_key[(3 - int'(key_pos)) * 8 +: 8];
                key_pos    = key_pos + 2'd1;
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                begin
                    key_pos     = 2'd0;
                    parse_phase = PH_HDR0;
                end
                queue_result(KIND_DATA, data, bytes_left == 16'd0);
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t got;
        frame_result_t want;
        if (!rst_n)
        begin
            parse_phase = PH_HDR0;
            first_hdr   = 8'h00;
            mask_on     = 1'b0;
            mask_key    = 32'h0;
            key_pos     = 2'd0;
            bytes_left  = 16'd0;
            len_hi      = 8'h00;
            pending_results.delete();
            fails       <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.kind    = kind_t'(kind);
                got.payload = payload;
                got.last    = last;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d payload=%02h last=%0d",
                             $time, got.kind, got.payload, got.last);
                    fails <= fails + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.payload !== want.payload ||
                        got.last !== want.last)
                    begin
                        $display("%0t: kind/payload/last expected %0d/%02h/%0d got %0d/%02h/%0d",
                                 $time, want.kind, want.payload, want.last,
                                 got.kind, got.payload, got.last);
                        fails <= fails + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                deframe(rx_byte);
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== sim/tb_websocket_frame_deframer_core.sv =====
module tb_websocket_frame_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import wsfd_pkg::*;

    typedef enum int {
        END_CLOSE,
        END_FRAGMENT,
        END_OVERSIZE,
        END_OVERSIZE_EXT
    } ending_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [1:0] kind;
    logic [7:0] payload;
    logic       last;

    int fails;
    int outstanding;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int bytes_sent = 0;

    websocket_frame_deframer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .payload   (payload),
        .last      (last)
    );

    wsfd_frame_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .payload     (payload),
        .last        (last),
        .fails       (fails),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // hold off new requests until every result is back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] data_header();
        logic [7:0] hdr;
        hdr            = 8'($urandom);
        hdr[FIN_BIT]   = 1'b1;
        hdr[CLOSE_BIT] = 1'b0;
        return hdr;
    endfunction

    task automatic send_random_frame();
        int   len;
        int   pick;
        bit   ext;
        logic use_key;
        pick = $urandom_range(99);
        ext  = 1'b0;
        if (pick < 60)
            len = $urandom_range(6);
        else if (pick < 85)
            len = $urandom_range(30, 7);
        else if (pick < 95)
            len = $urandom_range(125, 31);
        else
        begin
            ext = 1'b1;
            len = ($urandom_range(3) == 0) ? $urandom_range(300, 256) : $urandom_range(140);
            if (len == EXT_OVERSIZE)
                len++;
        end
        use_key = 1'($urandom_range(1));
        send_byte(data_header());
        if (ext)
        begin
            send_byte({use_key, LEN_EXT16});
            send_byte(8'(len >> 8));
            send_byte(8'(len));
        end
        else
            send_byte({use_key, 7'(len)});
        if (use_key)
            repeat (4) send_byte(8'($urandom));
        repeat (len) send_byte(8'($urandom));
    endtask

    task automatic send_ending();
        logic [7:0] hdr;
        case (ending_t'($urandom_range(3)))
            END_CLOSE:
            begin
                hdr            = 8'($urandom);
                hdr[CLOSE_BIT] = 1'b1;
                send_byte(hdr);
                send_byte(8'($urandom));
            end
            END_FRAGMENT:
            begin
                hdr            = 8'($urandom);
                hdr[CLOSE_BIT] = 1'b0;
                hdr[FIN_BIT]   = 1'b0;
                send_byte(hdr);
                send_byte(8'($urandom));
            end
            END_OVERSIZE:
            begin
                send_byte(data_header());
                send_byte({1'($urandom_range(1)), LEN_OVERSIZE});
            end
            default:
            begin
                send_byte(data_header());
                send_byte({1'($urandom_range(1)), LEN_EXT16});
                send_byte(EXT_OVERSIZE[15:8]);
                send_byte(EXT_OVERSIZE[7:0]);
            end
        endcase
    endtask

    initial
    begin
        logic [7:0] directed_bytes[] = '{
            8'h81, 8'h00,
            8'h82, 8'h80, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
            8'h80, 8'h7E, 8'h00, 8'h00,
            8'hF7, 8'h83, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h3C,
            8'h81, 8'h01, 8'hFF
        };
        int idle_by_phase[4]  = '{0, 74, 0, 36};
        int stall_by_phase[4] = '{0, 0, 74, 36};
        int target;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        for (int p = 0; p < 4; p++)
        begin
            hold_until_drained();
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            target    = bytes_sent + 70;
            while (bytes_sent < target)
                send_random_frame();
        end

        // close or error last: the block ignores everything after it
        hold_until_drained();
        send_ending();
        repeat (8) send_byte(8'($urandom));

        hold_until_drained();
        repeat (5) @(posedge clk);
        if (fails == 0 && outstanding == 0)
            $display("websocket_frame_deframer_core verification clean");
        else
            $display("websocket_frame_deframer_core verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("websocket_frame_deframer_core verification failed");
        $finish;
    end

endmodule
